// File: hw/rtl/wsp_pkg.sv
// Wheel speed PID package: shared constants, item structs, sequencer states
// and the Q.16 round-and-saturate helper.
// Used by wheel_speed_pid and its bench; depends on nothing.
package wsp_pkg;

  // Wheel constants
  localparam int COUNTS_PER_REV = 12;
  localparam int GEAR_RATIO     = 200;
  localparam int DRIVE_LIMIT    = 999;

  // Time scaling
  localparam int MS_PER_S    = 1000;
  localparam int S_PER_MIN   = 60;
  localparam int MS_PER_MIN  = MS_PER_S * S_PER_MIN;
  localparam int MS_PER_MIN_W = $clog2(MS_PER_MIN + 1);
  localparam int MS_PER_S_W  = $clog2(MS_PER_S + 1);

  // Pulses per output revolution
  localparam int GC   = COUNTS_PER_REV * GEAR_RATIO;
  localparam int GC_W = $clog2(GC + 1);

  // Field widths
  localparam int CMD_W  = 12;
  localparam int CNT_W  = 16;
  localparam int MS_W   = 10;
  localparam int DRV_W  = 11;
  localparam int RPM_W  = 16;
  localparam int GAIN_W = 24;

  // Datapath widths
  localparam int VAL_W  = 64;                 // signed working values
  localparam int ACC_W  = 74;                 // shift-add product
  localparam int MB_W   = GAIN_W;             // multiplier shift register
  localparam int DIV_W  = 64;                 // restoring divider
  localparam int IT_W   = $clog2(DIV_W + 1);
  localparam int TERM_W = 47;                 // saturated term magnitude
  localparam int P_W    = TERM_W + 1;         // signed P term
  localparam int RDEN_W = MS_W + GC_W;
  localparam longint EXP_MAX =
    (longint'(2048) * GC * 1023 * 65536 + MS_PER_MIN / 2) / MS_PER_MIN;
  localparam int EXP_W  = $clog2(EXP_MAX + 1);

  // Limits
  localparam int     DRIVE_CAP = (DRIVE_LIMIT > 1023) ? 1023 : DRIVE_LIMIT;
  localparam longint INT_LIM   = longint'(DRIVE_LIMIT) * 65536;
  localparam int     INT_W     = $clog2(INT_LIM + 1) + 1;
  localparam int     RPM_MAX   = 32767;
  localparam logic [TERM_W-1:0] TERM_CAP = '1;
  localparam int     Q16_HALF  = 32768;

  // Gain reset values
  localparam logic [GAIN_W-1:0] PROP_RST  = GAIN_W'(655360);
  localparam logic [GAIN_W-1:0] INTEG_RST = GAIN_W'(1310720);
  localparam logic [GAIN_W-1:0] DERIV_RST = GAIN_W'(983);

  // Register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV = 2'd2;

  typedef struct packed {
    logic signed [CMD_W-1:0] command_rpm;
    logic signed [CNT_W-1:0] encoder_count;
    logic        [MS_W-1:0]  elapsed_ms;
  } wsp_in_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] drive;
    logic signed [RPM_W-1:0] measured_rpm;
    logic                    encoder_restart;
  } wsp_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ZERO,
    ST_EXP_M1,
    ST_EXP_M2,
    ST_EXP_D,
    ST_RPM_M1,
    ST_RPM_M2,
    ST_RPM_D,
    ST_ERR,
    ST_P_M,
    ST_I_M1,
    ST_I_M2,
    ST_I_D,
    ST_D_M1,
    ST_D_M2,
    ST_D_D,
    ST_FIN,
    ST_SUM,
    ST_OUT
  } wsp_state_t;

  // round(x / 2^16), ties up, magnitude capped at TERM_CAP
  function automatic logic [TERM_W-1:0] sat_q16(input logic [ACC_W-1:0] x);
    logic [ACC_W-1:0] r;
    r = (x + ACC_W'(Q16_HALF)) >> 16;
    if (r > ACC_W'(TERM_CAP)) return TERM_CAP;
    else return r[TERM_W-1:0];
  endfunction

endpackage

// File: hw/rtl/wheel_speed_pid.sv
// Wheel speed PID top level: sequencer with a shared bit-serial
// shift-add multiplier and restoring divider.
// Depends on wsp_pkg.
//
// Usage:
//   in_valid/in_stall/in_data carry one control tick (command rpm, encoder
//   pulses, elapsed ms). out_valid/out_stall/out_data return one result
//   (drive, measured rpm, encoder restart flag) per tick.
//   cfg_we/cfg_index/cfg_wdata write the three gains; write only when idle.
//   A zero command skips the arithmetic and returns a zero result. Any
//   other command runs 13 multiply/divide phases, one multiplier bit or one
//   quotient bit per cycle. One item is in work at a time; in_stall is high
//   while the sequencer is busy, and the input is free again once the
//   result has been written to the output register.
//   The finished result sits in an output register, so a new
//   item can be taken while out_stall holds the previous one; the next
//   result waits in its last step until the register frees.
//   Reset (rst_n low, synchronous) restores default gains and clears the
//   loop state, the restart flag and the output valid flag.
module wheel_speed_pid
  import wsp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wsp_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wsp_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_wdata
);

  wsp_state_t state_r, state_nxt;
  logic [IT_W-1:0] it_r, it_last;
  logic            done, in_acc, out_free;

  // gains
  logic [GAIN_W-1:0] prop_r, integ_r, deriv_r;

  // loop state
  logic                    pend_r;
  logic signed [INT_W-1:0] isum_r;
  logic signed [P_W-1:0]   prev_r;
  logic signed [DRV_W-1:0] held_r;

  // item registers
  logic [CMD_W-1:0]        cmdm_r;
  logic                    cmd_neg_r;
  logic signed [CNT_W-1:0] cnt_r;
  logic [MS_W-1:0]         ms_r;
  logic                    restarted_r;
  logic [EXP_W-1:0]        expm_r;
  logic [RDEN_W-1:0]       rden_r;
  logic signed [RPM_W-1:0] rpm_r;
  logic [VAL_W-1:0]        errm_r;
  logic                    err_neg_r;
  logic signed [P_W-1:0]   p_r;
  logic signed [VAL_W-1:0] inc_r;
  logic                    diff_neg_r;
  logic signed [VAL_W-1:0] sum_r;
  wsp_out_t                out_data_r;
  logic                    out_valid_r;

  // serial arithmetic unit
  logic [ACC_W-1:0] a_r, acc_r, ld_a;
  logic [MB_W-1:0]  b_r, ld_b;
  logic [DIV_W-1:0] num_r, rem_r, den_r, ld_num, ld_den, remw;
  logic             is_mul, is_div;

  // derived values
  logic [CNT_W-1:0]        cntm;
  logic [TERM_W-1:0]       q_sat;
  logic signed [VAL_W-1:0] exp_s, cnt_ext, err_s, d_s, ibase, isum_t;
  logic signed [P_W:0]     diff;
  logic [P_W-1:0]          diffm;
  logic [VAL_W-1:0]        sum_abs, drv_mag;
  logic [9:0]              cap_mag;
  logic signed [DRV_W-1:0] drv;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign done      = (it_r == it_last);

  // combinational helpers
  assign cntm    = cnt_r[CNT_W-1] ? CNT_W'(-cnt_r) : CNT_W'(cnt_r);
  assign q_sat   = sat_q16(acc_r);
  assign exp_s   = cmd_neg_r ? -$signed(VAL_W'(expm_r)) : $signed(VAL_W'(expm_r));
  assign cnt_ext = {{(VAL_W-CNT_W){cnt_r[CNT_W-1]}}, cnt_r};
  assign err_s   = exp_s - (cnt_ext <<< 16);
  assign diff    = {p_r[P_W-1], p_r} - {prev_r[P_W-1], prev_r};
  assign diffm   = diff[P_W] ? P_W'(-diff) : P_W'(diff);
  assign d_s     = diff_neg_r ? $signed(num_r) : -$signed(num_r);
  assign ibase   = (integ_r == '0) ? '0 : {{(VAL_W-INT_W){isum_r[INT_W-1]}}, isum_r};
  assign isum_t  = ibase + inc_r;
  assign sum_abs = sum_r[VAL_W-1] ? VAL_W'(-sum_r) : VAL_W'(sum_r);
  assign drv_mag = sum_abs >> 16;
  assign cap_mag = (drv_mag > VAL_W'(DRIVE_CAP)) ? 10'(DRIVE_CAP) : drv_mag[9:0];
  assign drv     = sum_r[VAL_W-1] ? -$signed({1'b0, cap_mag}) : $signed({1'b0, cap_mag});
  assign remw    = {rem_r[DIV_W-2:0], num_r[DIV_W-1]};

  // operand selection per phase
  always_comb begin
    is_mul  = 1'b0;
    is_div  = 1'b0;
    it_last = '0;
    ld_a    = '0;
    ld_b    = '0;
    ld_num  = '0;
    ld_den  = '0;
    unique case (state_r)
      ST_EXP_M1: begin
        is_mul = 1'b1; it_last = IT_W'(MS_W);
        ld_a = ACC_W'(cmdm_r); ld_b = MB_W'(ms_r);
      end
      ST_EXP_M2: begin
        is_mul = 1'b1; it_last = IT_W'(GC_W);
        ld_a = acc_r; ld_b = MB_W'(GC);
      end
      ST_EXP_D: begin
        is_div = 1'b1; it_last = IT_W'(DIV_W);
        ld_num = DIV_W'(acc_r << 16) + DIV_W'(MS_PER_MIN / 2);
        ld_den = DIV_W'(MS_PER_MIN);
      end
      ST_RPM_M1: begin
        is_mul = 1'b1; it_last = IT_W'(GC_W);
        ld_a = ACC_W'(ms_r); ld_b = MB_W'(GC);
      end
      ST_RPM_M2: begin
        is_mul = 1'b1; it_last = IT_W'(MS_PER_MIN_W);
        ld_a = ACC_W'(cntm); ld_b = MB_W'(MS_PER_MIN);
      end
      ST_RPM_D: begin
        is_div = 1'b1; it_last = IT_W'(DIV_W);
        ld_num = DIV_W'(acc_r); ld_den = DIV_W'(rden_r);
      end
      ST_P_M: begin
        is_mul = 1'b1; it_last = IT_W'(GAIN_W);
        ld_a = ACC_W'(errm_r); ld_b = prop_r;
      end
      ST_I_M1: begin
        is_mul = 1'b1; it_last = IT_W'(GAIN_W);
        ld_a = ACC_W'(errm_r); ld_b = integ_r;
      end
      ST_I_M2: begin
        is_mul = 1'b1; it_last = IT_W'(MS_W);
        ld_a = ACC_W'(q_sat); ld_b = MB_W'(ms_r);
      end
      ST_I_D: begin
        is_div = 1'b1; it_last = IT_W'(DIV_W);
        ld_num = DIV_W'(acc_r) + DIV_W'(MS_PER_S / 2);
        ld_den = DIV_W'(MS_PER_S);
      end
      ST_D_M1: begin
        is_mul = 1'b1; it_last = IT_W'(GAIN_W);
        ld_a = ACC_W'(diffm); ld_b = deriv_r;
      end
      ST_D_M2: begin
        is_mul = 1'b1; it_last = IT_W'(MS_PER_S_W);
        ld_a = ACC_W'(q_sat); ld_b = MB_W'(MS_PER_S);
      end
      ST_D_D: begin
        is_div = 1'b1; it_last = IT_W'(DIV_W);
        ld_num = DIV_W'(acc_r) + DIV_W'(ms_r >> 1);
        ld_den = DIV_W'(ms_r);
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) begin
        state_nxt = (in_data.command_rpm == '0) ? ST_ZERO : ST_EXP_M1;
      end
      ST_ZERO:   if (out_free) state_nxt = ST_IDLE;
      ST_EXP_M1: if (done) state_nxt = ST_EXP_M2;
      ST_EXP_M2: if (done) state_nxt = ST_EXP_D;
      ST_EXP_D:  if (done) state_nxt = ST_RPM_M1;
      ST_RPM_M1: if (done) state_nxt = ST_RPM_M2;
      ST_RPM_M2: if (done) state_nxt = ST_RPM_D;
      ST_RPM_D:  if (done) state_nxt = ST_ERR;
      ST_ERR:    state_nxt = ST_P_M;
      ST_P_M:    if (done) state_nxt = ST_I_M1;
      ST_I_M1:   if (done) state_nxt = ST_I_M2;
      ST_I_M2:   if (done) state_nxt = ST_I_D;
      ST_I_D:    if (done) state_nxt = ST_D_M1;
      ST_D_M1:   if (done) state_nxt = ST_D_M2;
      ST_D_M2:   if (done) state_nxt = ST_D_D;
      ST_D_D:    if (done) state_nxt = ST_FIN;
      ST_FIN:    state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state, phase counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      it_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) it_r <= '0;
      else if (!done) it_r <= it_r + 1'b1;
    end
  end

  // gains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_r  <= PROP_RST;
      integ_r <= INTEG_RST;
      deriv_r <= DERIV_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROP:  prop_r  <= cfg_wdata;
        CFG_INTEG: integ_r <= cfg_wdata;
        CFG_DERIV: deriv_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // loop state and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      isum_r      <= '0;
      prev_r      <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (in_acc) begin
        if (in_data.command_rpm == '0) begin
          pend_r <= 1'b1;
          isum_r <= '0;
          prev_r <= '0;
        end else begin
          pend_r <= 1'b0;
        end
      end
      if (state_r == ST_FIN) begin
        prev_r <= p_r;
        if (isum_t > INT_LIM) isum_r <= INT_W'(INT_LIM);
        else if (isum_t < -INT_LIM) isum_r <= INT_W'(-INT_LIM);
        else isum_r <= INT_W'(isum_t);
      end
      if ((state_r == ST_OUT || state_r == ST_ZERO) && out_free) begin
        out_valid_r <= 1'b1;
        if (state_r == ST_OUT && p_r != '0) held_r <= drv;
      end
    end
  end

  // serial multiplier and divider
  always_ff @(posedge clk) begin
    if (is_mul) begin
      if (it_r == '0) begin
        a_r   <= ld_a;
        b_r   <= ld_b;
        acc_r <= '0;
      end else begin
        if (b_r[0]) acc_r <= acc_r + a_r;
        a_r <= a_r << 1;
        b_r <= b_r >> 1;
      end
    end
    if (is_div) begin
      if (it_r == '0) begin
        num_r <= ld_num;
        den_r <= ld_den;
        rem_r <= '0;
      end else if (remw >= den_r) begin
        rem_r <= remw - den_r;
        num_r <= {num_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= remw;
        num_r <= {num_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  // item payload captures
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_neg_r   <= in_data.command_rpm[CMD_W-1];
      cmdm_r      <= in_data.command_rpm[CMD_W-1] ? CMD_W'(-in_data.command_rpm)
                                                  : CMD_W'(in_data.command_rpm);
      ms_r        <= (in_data.elapsed_ms == '0) ? MS_W'(1) : in_data.elapsed_ms;
      cnt_r       <= pend_r ? '0 : in_data.encoder_count;
      restarted_r <= pend_r;
    end
    if (state_r == ST_RPM_M1 && it_r == '0) expm_r <= num_r[EXP_W-1:0];
    if (state_r == ST_RPM_M2 && it_r == '0) rden_r <= acc_r[RDEN_W-1:0];
    if (state_r == ST_ERR) begin
      if (num_r > DIV_W'(RPM_MAX))
        rpm_r <= cnt_r[CNT_W-1] ? -RPM_W'(RPM_MAX) : RPM_W'(RPM_MAX);
      else
        rpm_r <= cnt_r[CNT_W-1] ? -$signed(num_r[RPM_W-1:0]) : $signed(num_r[RPM_W-1:0]);
      err_neg_r <= err_s[VAL_W-1];
      errm_r    <= err_s[VAL_W-1] ? VAL_W'(-err_s) : VAL_W'(err_s);
    end
    if (state_r == ST_I_M1 && it_r == '0)
      p_r <= err_neg_r ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
    if (state_r == ST_D_M1 && it_r == '0) begin
      inc_r      <= err_neg_r ? -$signed(num_r) : $signed(num_r);
      diff_neg_r <= diff[P_W];
    end
    if (state_r == ST_FIN) sum_r <= {{(VAL_W-P_W){p_r[P_W-1]}}, p_r} + d_s;
    if (state_r == ST_SUM) sum_r <= sum_r + {{(VAL_W-INT_W){isum_r[INT_W-1]}}, isum_r};
    if (state_r == ST_ZERO && out_free) begin
      out_data_r.drive           <= '0;
      out_data_r.measured_rpm    <= '0;
      out_data_r.encoder_restart <= 1'b0;
    end
    if (state_r == ST_OUT && out_free) begin
      out_data_r.drive           <= (p_r != '0) ? drv : held_r;
      out_data_r.measured_rpm    <= rpm_r;
      out_data_r.encoder_restart <= restarted_r;
    end
  end

  // checks
  a_zero_sets_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.command_rpm == '0) |=> pend_r)
    else $error("zero command did not arm encoder restart");

  a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.drive <= DRV_W'(DRIVE_CAP) &&
                     out_data_r.drive >= -DRV_W'(DRIVE_CAP)))
    else $error("drive outside limit");

  a_integral_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (isum_r <= INT_W'(INT_LIM) && isum_r >= INT_W'(-INT_LIM)))
    else $error("integral outside limit");

endmodule

// File: sim/wheel_speed_pid_tb.sv
// Self-checking bench for wheel_speed_pid: directed and random control ticks
// checked against a Q.16 loop predictor held in a small scoreboard class.
// Depends on wsp_pkg and the wheel_speed_pid RTL.
`timescale 1ns / 100ps

module wheel_speed_pid_tb
  import wsp_pkg::*;
();

  localparam longint SPEED_CAP = (longint'(1) << 47) - 1;
  localparam longint PROD_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int     HOLD_LEN  = 3000;
  localparam int     STUCK_MAX = 20000;
  localparam int     SETTLE    = 500;

  // Loop predictor and the queue of ticks still owed by the block
  class pid_scoreboard;
    logic [GAIN_W-1:0] kp, ki, kd;
    longint integ_acc, last_p, drive_hold;
    bit restart_due;
    wsp_out_t owed[$];
    int errors;

    function new();
      kp = PROP_RST; ki = INTEG_RST; kd = DERIV_RST;
      integ_acc = 0; last_p = 0; drive_hold = 0; restart_due = 0;
      errors = 0;
    endfunction

    function void set_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
      case (idx)
        CFG_PROP:  kp = val;
        CFG_INTEG: ki = val;
        CFG_DERIV: kd = val;
        default: ;
      endcase
    endfunction

    // round(a / den), ties away from zero
    function longint rdiv(longint a, longint den);
      longint m;
      m = (a < 0) ? -a : a;
      m = (m + den / 2) / den;
      return (a < 0) ? -m : m;
    endfunction

    // round(a * g / 2^16), magnitude capped at 2^47-1
    function longint mulq(longint a, logic [GAIN_W-1:0] g);
      longint unsigned m, r, gu;
      gu = g;
      m = (a < 0) ? -a : a;
      if (gu != 0 && m > PROD_MAX / gu) r = SPEED_CAP;
      else begin
        r = (m * gu + 32768) >> 16;
        if (r > SPEED_CAP) r = SPEED_CAP;
      end
      return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function longint lim(longint v, longint l);
      return (v > l) ? l : ((v < -l) ? -l : v);
    endfunction

    function void note(wsp_in_t it);
      longint cmd, cnt, ms, target, err, p, inc, d, sum, drv, rpm;
      wsp_out_t r;
      cmd = longint'(it.command_rpm);
      cnt = longint'(it.encoder_count);
      ms  = it.elapsed_ms;
      r = '0;
      if (ms == 0) ms = 1;
      if (cmd == 0) begin
        // stop: clear loop state, keep held drive
        restart_due = 1;
        integ_acc = 0;
        last_p = 0;
        owed.push_back(r);
        return;
      end
      if (restart_due) begin
        restart_due = 0;
        cnt = 0;
        r.encoder_restart = 1;
      end
      target = rdiv(cmd * GEAR_RATIO * COUNTS_PER_REV * ms * 65536, 60000);
      rpm = lim((cnt * 60000) / (ms * COUNTS_PER_REV * GEAR_RATIO), 32767);
      err = target - cnt * 65536;
      if (ki == 0) integ_acc = 0;
      p = mulq(err, kp);
      inc = rdiv(mulq(err, ki) * ms, 1000);
      d = -rdiv(mulq(p - last_p, kd) * 1000, ms);
      last_p = p;
      integ_acc = lim(integ_acc + inc, longint'(DRIVE_LIMIT) * 65536);
      if (p != 0) begin
        sum = p + integ_acc + d;
        drv = (sum < 0) ? -((-sum) >>> 16) : (sum >>> 16);
        drive_hold = lim(drv, DRIVE_CAP);
      end
      drive_hold = lim(drive_hold, DRIVE_CAP);
      r.drive = drive_hold[DRV_W-1:0];
      r.measured_rpm = rpm[RPM_W-1:0];
      owed.push_back(r);
    endfunction

    function void check(wsp_out_t got);
      wsp_out_t exp_r;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = owed.pop_front();
      if (got.drive !== exp_r.drive) begin
        $display("%0t: drive exp %0d got %0d", $time, exp_r.drive, got.drive);
        errors++;
      end
      if (got.measured_rpm !== exp_r.measured_rpm) begin
        $display("%0t: measured_rpm exp %0d got %0d", $time,
                 exp_r.measured_rpm, got.measured_rpm);
        errors++;
      end
      if (got.encoder_restart !== exp_r.encoder_restart) begin
        $display("%0t: encoder_restart exp %0b got %0b", $time,
                 exp_r.encoder_restart, got.encoder_restart);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  wsp_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  wsp_out_t out_data;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PROP;
  logic [GAIN_W-1:0] cfg_wdata = '0;

  pid_scoreboard sb = new();
  int send_idle = 35;
  int recv_idle = 88;
  bit hold_req = 0;
  int hold_left = 0;
  int stuck = 0;

  wheel_speed_pid dut (.*);

  always #5 clk = ~clk;

  // Receiver stall pattern, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Result checking and watchdog
  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check(out_data);
    if ((out_valid && !out_stall) || (in_valid && !in_stall) || !rst_n) stuck = 0;
    else stuck++;
    if (stuck >= STUCK_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_tick(input wsp_in_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note(it);
  endtask

  task automatic tick(input int cmd, input int cnt, input int ms);
    wsp_in_t it;
    it.command_rpm = CMD_W'(cmd);
    it.encoder_count = CNT_W'(cnt);
    it.elapsed_ms = MS_W'(ms);
    send_tick(it);
  endtask

  // Mostly plausible ticks near the commanded speed, some stops and noise
  task automatic random_ticks(input int n);
    int cmd, ms, cnt, sel;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        tick(0, $urandom, $urandom);
      end else if (sel < 22) begin
        tick($urandom, $urandom, $urandom);
      end else begin
        cmd = $urandom_range(4095) - 2048;
        ms = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(60);
        cnt = (cmd * ms) / 25 + $urandom_range(40) - 20;
        tick(cmd, cnt, ms);
      end
    end
  endtask

  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_gain(idx, val);
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                           input logic [GAIN_W-1:0] d);
    write_gain(CFG_PROP, p);
    write_gain(CFG_INTEG, i);
    write_gain(CFG_DERIV, d);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: field extremes, stop and restart, zero time, zero P
    tick(2047, 32767, 1023);
    tick(-2048, -32768, 0);
    tick(100, 4, 1);
    tick(0, 123, 5);
    tick(300, 500, 10);
    tick(-300, -120, 10);
    tick(25, 1, 1);
    tick(25, 1, 1);
    tick(1, 0, 0);
    tick(-1, 32767, 1);
    tick(2047, -32768, 1);
    tick(0, 0, 0);
    tick(-2048, 32767, 1023);
    tick(500, 20, 1);
    random_ticks(280);
    drain();

    // Maximum gains, sender and receiver idling swapped
    send_idle = 88;
    recv_idle = 35;
    set_gains('1, '1, '1);
    random_ticks(120);
    drain();

    // Zero gains: P always zero, integral cleared
    set_gains('0, '0, '0);
    tick(25, 1, 1);
    random_ticks(80);
    drain();

    // Random gains, no idling, one long receiver hold-off
    send_idle = 0;
    recv_idle = 0;
    set_gains(GAIN_W'($urandom), GAIN_W'($urandom_range(65536 * 40)),
              GAIN_W'($urandom_range(4000)));
    hold_req = 1;
    random_ticks(200);
    drain();

    set_gains(PROP_RST, INTEG_RST, DERIV_RST);
    random_ticks(200);
    drain();

    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
